// File: rtl/oxygen_sensor_frame_parser_defines.svh
// Assertion macros for the oxygen sensor frame parser.
`ifndef OXYGEN_SENSOR_FRAME_PARSER_DEFINES_SVH
`define OXYGEN_SENSOR_FRAME_PARSER_DEFINES_SVH

// ante must be followed by cons in the same cycle
`define OSFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("osfp assertion failed");

// cond must never hold
`define OSFP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("osfp assertion failed");

`endif

// File: rtl/osfp_pkg.sv
// Shared types and constants for the oxygen sensor frame parser.
package osfp_pkg;

  localparam logic [7:0] HEADER_BYTE   = 8'h78;
  localparam logic [7:0] PREAMBLE_BYTE = 8'h09;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [7:0] STAT_SENSOR   = 8'h01;
  localparam logic [7:0] STAT_HEATING  = 8'h02;

  localparam logic [3:0] IDX_HEADER   = 4'd0;
  localparam logic [3:0] IDX_PREAMBLE = 4'd1;
  localparam logic [3:0] IDX_READ_HI  = 4'd2;
  localparam logic [3:0] IDX_READ_LO  = 4'd3;
  localparam logic [3:0] IDX_STATUS   = 4'd8;
  localparam logic [3:0] IDX_TRAIL0   = 4'd9;
  localparam logic [3:0] IDX_TRAIL1   = 4'd10;
  localparam logic [3:0] IDX_LAST     = 4'd11;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SENSOR_ERR   = 3'd1,
    ST_HEATING      = 3'd2,
    ST_BAD_PREAMBLE = 3'd3,
    ST_BAD_TRAILER  = 3'd4,
    ST_BAD_CHECKSUM = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] data;
  } item_t;

endpackage

// File: rtl/oxygen_sensor_frame_parser.sv
// Top level of the oxygen sensor frame parser.
// Takes one received byte per beat, one beat per cycle when the queue has room. Bytes
// outside a frame are dropped until a 0x78 header; the header and the next eleven bytes
// form a frame, and the twelfth byte yields one result beat (reading and status), held
// in an output register until taken. A QUEUE_DEPTH-entry queue between the hunter and
// the checker absorbs output stalls; the input stalls only when it fills. Every other
// byte produces no output.
`include "oxygen_sensor_frame_parser_defines.svh"

module oxygen_sensor_frame_parser #(
  parameter int QUEUE_DEPTH = osfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // [15:0] oxygen_tenths, [18:16] frame_status, [23:19] zero
);

  logic              push_valid;
  logic              push_ready;
  osfp_pkg::item_t   push_item;
  logic              pop_valid;
  logic              pop_ready;
  osfp_pkg::item_t   pop_item;
  logic [15:0]       res_oxygen;
  osfp_pkg::status_t res_status;

  osfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_ready   (s_tready),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  osfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  osfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready),
    .res_valid  (m_tvalid),
    .res_oxygen (res_oxygen),
    .res_status (res_status),
    .res_ready  (m_tready)
  );

  assign m_tdata = {5'd0, 3'(res_status), res_oxygen};

  `OSFP_ASSERT_NEVER(a_push_overflow, push_valid && !push_ready)
  `OSFP_ASSERT_IMPL(a_reading_only_ok, m_tvalid && res_status != osfp_pkg::ST_OK,
                    res_oxygen == 16'd0)
  `OSFP_ASSERT_IMPL(a_last_waits, pop_valid && !pop_ready,
                    m_tvalid && !m_tready && pop_item.idx == osfp_pkg::IDX_LAST)

endmodule

// File: rtl/osfp_front.sv
// Frame hunter: drops bytes outside a frame and tags frame bytes with their position.
module osfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_ready,
  output logic           push_valid,
  output osfp_pkg::item_t push_item,
  input  logic           push_ready
);

  logic       collecting;
  logic [3:0] byte_index;
  logic       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push_item.data = in_byte;
    push_item.idx  = collecting ? byte_index : osfp_pkg::IDX_HEADER;
    push_valid     = accept && (collecting || in_byte == osfp_pkg::HEADER_BYTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      byte_index <= '0;
    end else if (accept) begin
      if (!collecting) begin
        if (in_byte == osfp_pkg::HEADER_BYTE) begin
          collecting <= 1'b1;
          byte_index <= osfp_pkg::IDX_PREAMBLE;
        end
      end else if (byte_index == osfp_pkg::IDX_LAST) begin
        collecting <= 1'b0;
        byte_index <= '0;
      end else begin
        byte_index <= byte_index + 4'd1;
      end
    end
  end

endmodule

// File: rtl/osfp_queue.sv
// Small FIFO of tagged frame bytes between the hunter and the frame checker.
module osfp_queue #(
  parameter int DEPTH = osfp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  osfp_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output osfp_pkg::item_t pop_item,
  input  logic            pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  osfp_pkg::item_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/osfp_back.sv
// Frame checker: accumulates sum and fields, grades the frame, holds the result beat.
module osfp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  osfp_pkg::item_t pop_item,
  output logic            pop_ready,
  output logic            res_valid,
  output logic [15:0]     res_oxygen,
  output osfp_pkg::status_t res_status,
  input  logic            res_ready
);

  logic [7:0]  running_sum;
  logic [15:0] reading_hold;
  logic [7:0]  sensor_status_hold;
  logic        preamble_bad;
  logic        trailer_bad;
  logic        is_last;
  logic        do_pop;
  logic [7:0]  expect_sum;
  osfp_pkg::status_t status_next;
  logic [15:0] oxygen_next;

  assign is_last    = (pop_item.idx == osfp_pkg::IDX_LAST);
  assign pop_ready  = !is_last || !res_valid || res_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign expect_sum = ~running_sum + 8'd1;

  always_comb begin
    oxygen_next = '0;
    priority if (preamble_bad) begin
      status_next = osfp_pkg::ST_BAD_PREAMBLE;
    end else if (trailer_bad) begin
      status_next = osfp_pkg::ST_BAD_TRAILER;
    end else if (pop_item.data != expect_sum) begin
      status_next = osfp_pkg::ST_BAD_CHECKSUM;
    end else if (sensor_status_hold == osfp_pkg::STAT_SENSOR) begin
      status_next = osfp_pkg::ST_SENSOR_ERR;
    end else if (sensor_status_hold == osfp_pkg::STAT_HEATING) begin
      status_next = osfp_pkg::ST_HEATING;
    end else begin
      status_next = osfp_pkg::ST_OK;
      oxygen_next = reading_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      unique case (pop_item.idx)
        osfp_pkg::IDX_HEADER: begin
          running_sum        <= pop_item.data;
          reading_hold       <= '0;
          sensor_status_hold <= '0;
          preamble_bad       <= 1'b0;
          trailer_bad        <= 1'b0;
        end
        osfp_pkg::IDX_PREAMBLE: begin
          preamble_bad <= (pop_item.data != osfp_pkg::PREAMBLE_BYTE);
          running_sum  <= running_sum + pop_item.data;
        end
        osfp_pkg::IDX_READ_HI: begin
          reading_hold[15:8] <= pop_item.data;
          running_sum        <= running_sum + pop_item.data;
        end
        osfp_pkg::IDX_READ_LO: begin
          reading_hold[7:0] <= pop_item.data;
          running_sum       <= running_sum + pop_item.data;
        end
        osfp_pkg::IDX_STATUS: begin
          sensor_status_hold <= pop_item.data;
          running_sum        <= running_sum + pop_item.data;
        end
        osfp_pkg::IDX_TRAIL0, osfp_pkg::IDX_TRAIL1: begin
          if (pop_item.data != osfp_pkg::ZERO_BYTE) begin
            trailer_bad <= 1'b1;
          end
          running_sum <= running_sum + pop_item.data;
        end
        osfp_pkg::IDX_LAST: begin
          running_sum <= '0;
        end
        default: begin
          running_sum <= running_sum + pop_item.data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_pop && is_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && is_last) begin
      res_oxygen <= oxygen_next;
      res_status <= status_next;
    end
  end

endmodule

// File: tb/testbench.sv
// Testbench for the oxygen sensor frame parser: byte-stream stimulus, frame predictor, checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit         hold;
    logic [7:0] data;
  } rx_feed_t;

  typedef struct {
    logic [15:0]       tenths;
    osfp_pkg::status_t status;
  } frame_result_t;

  typedef enum {
    FAULT_NONE,
    FAULT_PREAMBLE,
    FAULT_TRAIL_A,
    FAULT_TRAIL_B,
    FAULT_SUM,
    FAULT_ALL
  } fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [15:0] oxygen_tenths, [18:16] frame_status, [23:19] zero

  rx_feed_t      rx_feed_q[$];
  frame_result_t frame_results_q[$];
  int            errors = 0;
  int            in_beats = 0;
  int            frame_bytes = 0;
  bit            steady;

  // predictor state
  bit          frame_open = 1'b0;
  logic [3:0]  frame_pos = '0;
  logic [7:0]  frame_sum = '0;
  logic [15:0] reading_acc = '0;
  logic [7:0]  status_acc = '0;
  bit          preamble_fault = 1'b0;
  bit          trailer_fault = 1'b0;

  oxygen_sensor_frame_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  assign steady = (in_beats >= 700) && (in_beats < 1000);

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0]    want;
    frame_result_t r;
    if (!frame_open) begin
      if (b == osfp_pkg::HEADER_BYTE) begin
        frame_open = 1'b1;
        frame_pos = osfp_pkg::IDX_PREAMBLE;
        frame_sum = b;
        reading_acc = '0;
        status_acc = '0;
        preamble_fault = 1'b0;
        trailer_fault = 1'b0;
      end
    end else if (frame_pos != osfp_pkg::IDX_LAST) begin
      case (frame_pos)
        osfp_pkg::IDX_PREAMBLE: preamble_fault = (b != osfp_pkg::PREAMBLE_BYTE);
        osfp_pkg::IDX_READ_HI: reading_acc[15:8] = b;
        osfp_pkg::IDX_READ_LO: reading_acc[7:0] = b;
        osfp_pkg::IDX_STATUS: status_acc = b;
        osfp_pkg::IDX_TRAIL0, osfp_pkg::IDX_TRAIL1: begin
          if (b != osfp_pkg::ZERO_BYTE) trailer_fault = 1'b1;
        end
        default: ;
      endcase
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      want = 8'h00 - frame_sum;
      r.tenths = '0;
      if (preamble_fault) r.status = osfp_pkg::ST_BAD_PREAMBLE;
      else if (trailer_fault) r.status = osfp_pkg::ST_BAD_TRAILER;
      else if (b != want) r.status = osfp_pkg::ST_BAD_CHECKSUM;
      else if (status_acc == osfp_pkg::STAT_SENSOR) r.status = osfp_pkg::ST_SENSOR_ERR;
      else if (status_acc == osfp_pkg::STAT_HEATING) r.status = osfp_pkg::ST_HEATING;
      else begin
        r.status = osfp_pkg::ST_OK;
        r.tenths = reading_acc;
      end
      frame_results_q.push_back(r);
      frame_open = 1'b0;
      frame_pos = '0;
      frame_sum = '0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    rx_feed_t it;
    it.hold = 1'b0;
    it.data = b;
    rx_feed_q.push_back(it);
  endtask

  task automatic queue_hold();
    rx_feed_t it;
    it.hold = 1'b1;
    it.data = '0;
    rx_feed_q.push_back(it);
  endtask

  task automatic queue_frame(input logic [15:0] reading, input logic [7:0] stat,
                             input fault_t fault, input bit mid_header);
    logic [7:0] f[12];
    logic [7:0] sum;
    f[0] = osfp_pkg::HEADER_BYTE;
    f[1] = osfp_pkg::PREAMBLE_BYTE;
    f[2] = reading[15:8];
    f[3] = reading[7:0];
    for (int i = 4; i < 8; i++) f[i] = mid_header ? osfp_pkg::HEADER_BYTE : 8'($urandom);
    f[8] = stat;
    f[9] = osfp_pkg::ZERO_BYTE;
    f[10] = osfp_pkg::ZERO_BYTE;
    if (fault == FAULT_PREAMBLE || fault == FAULT_ALL)
      f[1] = osfp_pkg::PREAMBLE_BYTE ^ 8'($urandom_range(255, 1));
    if (fault == FAULT_TRAIL_A || fault == FAULT_ALL) f[9] = 8'($urandom_range(255, 1));
    if (fault == FAULT_TRAIL_B || fault == FAULT_ALL) f[10] = 8'($urandom_range(255, 1));
    sum = '0;
    for (int i = 0; i < 11; i++) sum = sum + f[i];
    f[11] = 8'h00 - sum;
    if (fault == FAULT_SUM || fault == FAULT_ALL) f[11] = f[11] ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < 12; i++) queue_byte(f[i]);
    frame_bytes += 12;
  endtask

  // driver
  always @(posedge clk) begin
    rx_feed_t it;
    bit       go;
    go = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
        in_beats++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_feed_q.size() > 0 && rx_feed_q[0].hold) begin
          if (frame_results_q.size() == 0) void'(rx_feed_q.pop_front());
        end else if (rx_feed_q.size() > 0 && (steady || $urandom_range(99) >= 13)) begin
          it = rx_feed_q.pop_front();
          s_tdata <= it.data;
          go = 1'b1;
        end
        s_tvalid <= go;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_result_t r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $realtime, m_tdata);
          errors++;
        end else begin
          r = frame_results_q.pop_front();
          if (m_tdata[15:0] !== r.tenths) begin
            $display("%0t: oxygen_tenths mismatch, expected %h, actual %h",
                     $realtime, r.tenths, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[18:16] !== r.status) begin
            $display("%0t: frame_status mismatch, expected %0d, actual %0d",
                     $realtime, r.status, m_tdata[18:16]);
            errors++;
          end
          if (m_tdata[23:19] !== 5'd0) begin
            $display("%0t: pad bits mismatch, expected 0, actual %h",
                     $realtime, m_tdata[23:19]);
            errors++;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    int     pick;
    int     n;
    fault_t fault;
    logic [15:0] reading;
    logic [7:0]  stat;

    // noise while hunting, then a clean frame with the top reading and headers as data,
    // then a frame with every fault at once
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h77);
    queue_byte(osfp_pkg::PREAMBLE_BYTE);
    queue_frame(16'hFFFF, 8'h00, FAULT_NONE, 1'b1);
    queue_frame(16'h1234, osfp_pkg::STAT_SENSOR, FAULT_ALL, 1'b0);
    queue_hold();

    frame_bytes = 0;
    n = 0;
    while (frame_bytes < 1700) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(3) == 0) queue_byte(osfp_pkg::HEADER_BYTE);
          else queue_byte(8'($urandom));
        end
      end else begin
        case ($urandom_range(3))
          0: reading = 16'h0000;
          1: reading = 16'hFFFF;
          default: reading = 16'($urandom);
        endcase
        case ($urandom_range(4))
          0: stat = osfp_pkg::STAT_SENSOR;
          1: stat = osfp_pkg::STAT_HEATING;
          2: stat = osfp_pkg::ZERO_BYTE;
          default: stat = 8'($urandom);
        endcase
        pick = $urandom_range(99);
        if (pick < 55) fault = FAULT_NONE;
        else if (pick < 64) fault = FAULT_PREAMBLE;
        else if (pick < 73) fault = FAULT_TRAIL_A;
        else if (pick < 82) fault = FAULT_TRAIL_B;
        else if (pick < 94) fault = FAULT_SUM;
        else fault = FAULT_ALL;
        queue_frame(reading, stat, fault, $urandom_range(19) == 0);
        n++;
        if (n % 40 == 0) queue_hold();
      end
    end

    while (rx_feed_q.size() != 0 || s_tvalid || frame_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #400us;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/osfp_pkg.sv
rtl/osfp_front.sv
rtl/osfp_queue.sv
rtl/osfp_back.sv
rtl/oxygen_sensor_frame_parser.sv
tb/testbench.sv
